// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the tail-drop queue.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// check prop at every clock edge outside reset
`define ASSERT_CHK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// check prop at every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define ASSERT_CHK(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== design/sstdq_pkg.sv =====
// Package for the single-server tail-drop queue: widths, register map,
// word types and the control struct of the finish-time cells. No dependencies.
package sstdq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int ARG_W               = 32;
   localparam int TIME_W              = 48;
   localparam int LIMIT_W             = 4;
   localparam int CSR_ADDR_W          = 3;
   localparam int CSR_DATA_W          = 32;
   localparam int CSR_IDX_W           = 1;

   localparam logic [LIMIT_W-1:0]   LIMIT_RESET     = 4'd15;
   localparam logic [TIME_W-1:0]    FINISH_MAX      = {TIME_W{1'b1}};
   localparam logic [CSR_IDX_W-1:0] REG_QUEUE_LIMIT = 1'd0;

   typedef struct packed {
      logic [ARG_W-1:0] arrival_time;
      logic [ARG_W-1:0] service_duration;
   } req_word_type;

   typedef struct packed {
      logic [TIME_W-1:0] finish_time;
      logic              rejected;
   } rsp_word_type;

   typedef struct packed {
      logic             step;     // an item is taken this cycle: retire
      logic             shift;    // the item is admitted: move one cell down
      logic [ARG_W-1:0] arrival;
   } cell_ctrl_type;

endpackage

// ===== design/single_server_tail_drop_queue.sv =====
// Top level of the single-server tail-drop queue.
// Depends on sstdq_pkg, sstdq_cell and assert_macros.svh.
//
// Usage:
//  req_ channel: one word per request (arrival_time, service_duration), valid/ready.
//  rsp_ channel: one word per request (finish_time, rejected), valid/ready.
//  csr_ port: APB-style, register queue_limit at byte address 0, pready tied high.
// Pending finish times sit in a chain of QUEUE_DEPTH cells, newest in cell 0.
// Held finish times are kept in order, so every cell compares its own entry
// with the arrival at once; the held ones form a prefix of the chain and the
// admit test reads the cell at index queue_limit and the last cell.
// Response: the response word is registered and appears in the cycle after the request is taken.
// Throughput: one request per cycle while rsp_ready is high, set by the combinational
// cell compare and the 48-bit max/add that produce the finish time.
// Reset: queue empty, last finish zero, queue_limit 15; no clearing pass.
// Stall: while rsp_valid is high and rsp_ready low, req_ready is low and
// the response word holds; the chain only moves when a request is taken.
`include "assert_macros.svh"
module single_server_tail_drop_queue #(
   parameter int QUEUE_DEPTH = sstdq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  sstdq_pkg::req_word_type             req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sstdq_pkg::rsp_word_type             rsp_word,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sstdq_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [sstdq_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [sstdq_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   localparam int TW = sstdq_pkg::TIME_W;
   localparam int AW = sstdq_pkg::ARG_W;

   logic [sstdq_pkg::LIMIT_W-1:0] queue_limit_ff;
   logic [sstdq_pkg::LIMIT_W-1:0] queue_limit_in;
   logic [TW-1:0]                 last_finish_ff;
   logic [TW-1:0]                 last_finish_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   sstdq_pkg::rsp_word_type       rsp_word_ff;
   sstdq_pkg::rsp_word_type       rsp_word_in;

   logic                          csr_write;
   logic [sstdq_pkg::CSR_IDX_W-1:0] csr_index;
   logic                          req_fire;
   logic                          limit_hit;
   logic                          reject;
   logic [TW-1:0]                 arrival_ext;
   logic [TW-1:0]                 start_time;
   logic [TW:0]                   finish_sum;
   logic [TW-1:0]                 finish_new;
   sstdq_pkg::cell_ctrl_type      cell_ctrl;

   logic [QUEUE_DEPTH-1:0]        valid_vec;
   logic [QUEUE_DEPTH-1:0]        alive_vec;
   logic [TW-1:0]                 finish_arr [QUEUE_DEPTH];
   logic [QUEUE_DEPTH:0]          prefix_chk;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[sstdq_pkg::CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      queue_limit_in = queue_limit_ff;
      if (csr_write && csr_index == sstdq_pkg::REG_QUEUE_LIMIT) begin
         queue_limit_in = csr_pwdata[sstdq_pkg::LIMIT_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_index == sstdq_pkg::REG_QUEUE_LIMIT) begin
         csr_prdata = {{(sstdq_pkg::CSR_DATA_W-sstdq_pkg::LIMIT_W){1'b0}}, queue_limit_ff};
      end
   end

   // request side
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // held count after retiring exceeds the limit iff the cell at that index lives
   always_comb begin
      limit_hit = 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (int'(queue_limit_ff) == i) begin
            limit_hit = alive_vec[i];
         end
      end
   end

   assign reject = alive_vec[QUEUE_DEPTH-1] || limit_hit;

   assign arrival_ext = {{(TW-AW){1'b0}}, req_word.arrival_time};
   assign start_time  = (last_finish_ff > arrival_ext) ? last_finish_ff : arrival_ext;
   assign finish_sum  = {1'b0, start_time} +
                        {{(TW+1-AW){1'b0}}, req_word.service_duration};
   assign finish_new  = finish_sum[TW] ? sstdq_pkg::FINISH_MAX : finish_sum[TW-1:0];

   assign cell_ctrl.step    = req_fire;
   assign cell_ctrl.shift   = req_fire && !reject;
   assign cell_ctrl.arrival = req_word.arrival_time;

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic          chain_alive;
      logic [TW-1:0] chain_finish;
      if (g == 0) begin : g_head
         assign chain_alive  = 1'b1;
         assign chain_finish = finish_new;
      end else begin : g_body
         assign chain_alive  = alive_vec[g-1];
         assign chain_finish = finish_arr[g-1];
      end
      sstdq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl),
         .prev_alive  (chain_alive),
         .prev_finish (chain_finish),
         .cell_valid  (valid_vec[g]),
         .cell_alive  (alive_vec[g]),
         .cell_finish (finish_arr[g])
      );
   end

   always_comb begin
      last_finish_in = last_finish_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_word_in    = rsp_word_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         if (reject) begin
            rsp_word_in.finish_time = '0;
            rsp_word_in.rejected    = 1'b1;
         end else begin
            rsp_word_in.finish_time = finish_new;
            rsp_word_in.rejected    = 1'b0;
            last_finish_in          = finish_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_limit_ff <= sstdq_pkg::LIMIT_RESET;
         last_finish_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         queue_limit_ff <= queue_limit_in;
         last_finish_ff <= last_finish_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // held cells always form a prefix of the chain
   assign prefix_chk = {1'b0, valid_vec} + {{QUEUE_DEPTH{1'b0}}, 1'b1};

   `ASSERT_CHK(a_valid_prefix, clock, reset, $onehot(prefix_chk))
   `ASSERT_CHK(a_reject_zero, clock, reset, (rsp_valid_ff && rsp_word_ff.rejected) |-> (rsp_word_ff.finish_time == '0))
   `ASSERT_CHK(a_last_monotonic, clock, reset, !$past(reset) |-> (last_finish_ff >= $past(last_finish_ff)))
   `ASSERT_CHK(a_admit_to_head, clock, reset, (req_fire && !reject) |=> (valid_vec[0] && finish_arr[0] == rsp_word_ff.finish_time))

endmodule

// ===== design/sstdq_cell.sv =====
// One cell of the finish-time chain: holds one pending finish time.
// Depends on sstdq_pkg.
module sstdq_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  sstdq_pkg::cell_ctrl_type      ctrl,
   input  logic                          prev_alive,
   input  logic [sstdq_pkg::TIME_W-1:0]  prev_finish,
   output logic                          cell_valid,
   output logic                          cell_alive,
   output logic [sstdq_pkg::TIME_W-1:0]  cell_finish
);

   logic                         valid_ff;
   logic                         valid_in;
   logic [sstdq_pkg::TIME_W-1:0] finish_ff;
   logic [sstdq_pkg::TIME_W-1:0] finish_in;

   // held and still running after this arrival
   assign cell_alive  = valid_ff &&
      (finish_ff > {{(sstdq_pkg::TIME_W-sstdq_pkg::ARG_W){1'b0}}, ctrl.arrival});
   assign cell_valid  = valid_ff;
   assign cell_finish = finish_ff;

   always_comb begin
      valid_in  = valid_ff;
      finish_in = finish_ff;
      if (ctrl.step) begin
         if (ctrl.shift) begin
            valid_in  = prev_alive;
            finish_in = prev_finish;
         end else begin
            valid_in  = cell_alive;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      finish_ff <= finish_in;
   end

endmodule
